@@ rtl/core/cca_pkg.sv @@
// Shared types, widths and constants for the cluster centroid accumulator.
package cca_pkg;

    // Field widths fixed by the item formats
    localparam int COORD_W   = 32;
    localparam int LABEL_W   = 8;
    localparam int DIM_OUT_W = 6;
    localparam int SUM_W     = 48;

    // Defaults for the top-level parameters
    localparam int DIMENSIONS_DEF  = 8;
    localparam int MAX_OBJECTS_DEF = 65536;

    // Configuration port
    localparam int                   CFG_DATA_W  = 32;
    localparam int                   CFG_ADDR_W  = 1;
    localparam logic [CFG_ADDR_W-1:0] ADDR_TARGET = 1'b0;

    // Saturation limits of a Q16.16 result: the bounds as sum-width magnitudes, then the saturated values
    localparam logic [SUM_W-1:0] RES_POS_MAX = 48'h0000_7FFF_FFFF;
    localparam logic [SUM_W-1:0] RES_NEG_MAG = 48'h0000_8000_0000;
    localparam logic [COORD_W-1:0] RES_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] RES_NEG_SAT = 32'h8000_0000;

    // One input item
    typedef struct packed {
        logic signed [COORD_W-1:0] coordinate;
        logic [LABEL_W-1:0]        label;
        logic                      object_end;
        logic                      set_end;
    } t_cca_in;

    // One result item
    typedef struct packed {
        logic signed [COORD_W-1:0] centroid_value;
        logic [DIM_OUT_W-1:0]      dimension;
        logic                      final_res;
    } t_cca_res;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // input item taken this cycle
        logic rd_fetch;  // sum memory read at the result index
        logic div_load;  // load divider with the fetched sum
        logic div_step;  // one quotient bit
        logic emit;      // register a result item
        logic last;      // this result is the last dimension
        logic clear;     // drop sums and member count
    } t_cca_cmd;

endpackage

@@ rtl/core/cluster_centroid_accumulator_unit.sv @@
// Top level: k-means centroid accumulator with APB configuration.
//
// Coordinate items are taken one per cycle while busy is low: start with
// busy low accepts an item, and matching coordinates are summed into a
// 48-bit entry per dimension with no gap between items. An item carrying
// set_end raises busy through a flush and then, for each dimension, a sum
// memory fetch, a divider load, the bit-serial shift-subtract divide and
// the registering of the result, one result per dimension. Each result is
// presented for a single cycle with o_res_valid high and must be taken
// then; the block cannot be held off. The sums and count are cleared as
// the last result is issued, with no clearing pass after reset.
module cluster_centroid_accumulator_unit #(
    parameter int DIMENSIONS  = cca_pkg::DIMENSIONS_DEF,
    parameter int MAX_OBJECTS = cca_pkg::MAX_OBJECTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  cca_pkg::t_cca_in                   i_item,
    output logic                               o_res_valid,
    output cca_pkg::t_cca_res                  o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cca_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cca_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [cca_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import cca_pkg::*;

    localparam int DIM_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

    logic [LABEL_W-1:0] r_target;
    t_cca_cmd           cmd;
    logic [DIM_W-1:0]   idx;
    logic               cfg_wr;

    // Configuration register
    assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_TARGET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (cfg_wr) begin
            r_target <= pwdata[LABEL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TARGET) ? CFG_DATA_W'(r_target) : '0;

    cca_ctrl #(
        .DIMENSIONS (DIMENSIONS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_set_end (i_item.set_end),
        .o_busy    (busy),
        .o_cmd     (cmd),
        .o_idx     (idx)
    );

    cca_dp #(
        .DIMENSIONS  (DIMENSIONS),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_item      (i_item),
        .i_target    (r_target),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

@@ rtl/core/cca_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle while i_step is high.
module cca_div #(
    parameter int DIVISOR_W = 17
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_step,
    input  logic [cca_pkg::SUM_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]        i_divisor,
    output logic [cca_pkg::SUM_W-1:0]   o_quotient
);
    import cca_pkg::*;

    logic [SUM_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = ~diff[DIVISOR_W];
    end

    // Dividend shifts out at the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_quotient = r_quo;

endmodule

@@ rtl/core/cca_dp.sv @@
// Datapath: sum memory with accumulate stage, member count, divide and result register.
module cca_dp #(
    parameter int DIMENSIONS  = cca_pkg::DIMENSIONS_DEF,
    parameter int MAX_OBJECTS = cca_pkg::MAX_OBJECTS_DEF,
    localparam int DIM_W      = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cca_pkg::t_cca_cmd             i_cmd,
    input  logic [DIM_W-1:0]              i_idx,
    input  cca_pkg::t_cca_in              i_item,
    input  logic [cca_pkg::LABEL_W-1:0]   i_target,
    output logic                          o_res_valid,
    output cca_pkg::t_cca_res             o_res
);
    import cca_pkg::*;

    localparam int              CNT_W     = $clog2(MAX_OBJECTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_OBJECTS);
    localparam logic [DIM_W-1:0] POS_LAST = DIM_W'(DIMENSIONS - 1);

    // Sum memory and one valid bit per entry
    logic [SUM_W-1:0]      r_sums [DIMENSIONS];
    logic [DIMENSIONS-1:0] r_valid;
    logic [SUM_W-1:0]      r_rd_data;
    logic                  r_rd_vld;
    logic [DIM_W-1:0]      rd_addr;

    // Stream position and member count
    logic [DIM_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count;
    logic             match;
    logic             obj_done;

    // Accumulate stage
    logic                      r_a_vld;
    logic                      r_a_match;
    logic [DIM_W-1:0]          r_a_pos;
    logic signed [COORD_W-1:0] r_a_coord;
    logic [SUM_W-1:0]          old_sum;
    logic [SUM_W-1:0]          new_sum;
    logic                      a_wr;

    // Bypass of the write made in the previous cycle
    logic             r_f_vld;
    logic [DIM_W-1:0] r_f_pos;
    logic [SUM_W-1:0] r_f_sum;

    // Divide and result
    logic [SUM_W-1:0]   fetched;
    logic [SUM_W-1:0]   fetched_mag;
    logic               r_q_neg;
    logic [SUM_W-1:0]   quotient;
    logic [COORD_W-1:0] res_val;
    t_cca_res           r_res;
    logic               r_res_vld;

    // Match test and next position of the incoming item
    always_comb begin
        match    = (i_item.label == i_target) && (r_count < CNT_MAX);
        obj_done = i_item.object_end | i_item.set_end;
        if (obj_done || (r_pos == POS_LAST)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign rd_addr = i_cmd.rd_fetch ? i_idx : r_pos;

    // Old sum: bypass, else memory if written since the last clear, else zero
    always_comb begin
        if (r_f_vld && (r_f_pos == r_a_pos)) begin
            old_sum = r_f_sum;
        end else if (r_rd_vld) begin
            old_sum = r_rd_data;
        end else begin
            old_sum = '0;
        end
        new_sum = old_sum + {{(SUM_W-COORD_W){r_a_coord[COORD_W-1]}}, r_a_coord};
        a_wr    = r_a_vld & r_a_match;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_valid   <= '0;
            r_a_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_a_vld   <= i_cmd.accept;
            r_f_vld   <= a_wr;
            r_res_vld <= i_cmd.emit;
            if (i_cmd.accept) begin
                r_pos <= n_pos;
                if (obj_done && match) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (a_wr) begin
                r_valid[r_a_pos] <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_valid <= '0;
            end
        end
    end

    // Sum memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (a_wr) begin
            r_sums[r_a_pos] <= new_sum;
        end
        r_rd_data <= r_sums[rd_addr];
        r_rd_vld  <= r_valid[rd_addr];
    end

    // Accumulate stage and bypass payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a_match <= match;
            r_a_pos   <= r_pos;
            r_a_coord <= i_item.coordinate;
        end
        r_f_pos <= r_a_pos;
        r_f_sum <= new_sum;
    end

    // Magnitude and sign of the fetched sum for the divider
    always_comb begin
        fetched     = r_rd_vld ? r_rd_data : '0;
        fetched_mag = fetched[SUM_W-1] ? (~fetched + 1'b1) : fetched;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_q_neg <= fetched[SUM_W-1];
        end
    end

    cca_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (fetched_mag),
        .i_divisor  (r_count),
        .o_quotient (quotient)
    );

    // Sign restore and saturation to Q16.16
    always_comb begin
        if (r_count == '0) begin
            res_val = '0;
        end else if (r_q_neg) begin
            if (quotient > RES_NEG_MAG) begin
                res_val = RES_NEG_SAT;
            end else begin
                res_val = ~quotient[COORD_W-1:0] + 1'b1;
            end
        end else if (quotient > RES_POS_MAX) begin
            res_val = RES_POS_SAT;
        end else begin
            res_val = quotient[COORD_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.centroid_value <= res_val;
            r_res.dimension      <= DIM_OUT_W'(i_idx);
            r_res.final_res      <= i_cmd.last;
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

    // An empty cluster gives zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (r_count == '0)) |=> (o_res.centroid_value == '0))
        else $error("non-zero result for an empty cluster");

    // A matching coordinate leaves its entry marked as written
    a_entry_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && r_a_match) |=> r_valid[$past(r_a_pos)])
        else $error("sum entry not marked after accumulate");

endmodule

@@ rtl/core/cca_ctrl.sv @@
// Controller: item acceptance, flush, and per-dimension fetch/divide/emit sequence.
module cca_ctrl #(
    parameter int DIMENSIONS = cca_pkg::DIMENSIONS_DEF,
    localparam int DIM_W     = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_set_end,
    output logic              o_busy,
    output cca_pkg::t_cca_cmd o_cmd,
    output logic [DIM_W-1:0]  o_idx
);
    import cca_pkg::*;

    localparam int               STEP_W    = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
    localparam logic [DIM_W-1:0]  IDX_LAST  = DIM_W'(DIMENSIONS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FLUSH = 6'b000010,
        S_FETCH = 6'b000100,
        S_LOAD  = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [DIM_W-1:0]  r_idx, n_idx;
    logic [STEP_W-1:0] r_step, n_step;
    t_cca_cmd          cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.accept = i_start;
                if (i_start && i_set_end) begin
                    n_state = S_FLUSH;
                    n_idx   = '0;
                end
            end
            // last coordinate still being added
            S_FLUSH: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                cmd.rd_fetch = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                cmd.div_load = 1'b1;
                n_step       = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EMIT: begin
                cmd.emit  = 1'b1;
                cmd.last  = (r_idx == IDX_LAST);
                cmd.clear = cmd.last;
                if (cmd.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;
    assign o_idx  = r_idx;

    // A set-end item starts the flush
    a_set_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_set_end) |=> (r_state == S_FLUSH))
        else $error("set end did not start the result sequence");

    // A result only follows a full divide
    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_DIV && $past(r_step) == STEP_LAST))
        else $error("result emitted before the divide finished");

    // The last dimension returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_idx == IDX_LAST) |=> (r_state == S_IDLE))
        else $error("no return to idle after the last dimension");

endmodule
